[rtl/anm_pkg.sv]
// shared types, constants and reset values of the alarm notify manager
package anm_pkg;

  // widest alarm table that the configuration masks can describe
  localparam int MAX_ALARMS = 32;

  // defaults of the top level parameters
  localparam int NUM_ALARMS_DEF = 27;
  localparam int COUNT_BITS_DEF = 16;

  // width of the per-entry notice age counter
  localparam int AGE_BITS = 17;

  // input commands
  localparam logic [1:0] CMD_RAISE   = 2'd0;
  localparam logic [1:0] CMD_RESOLVE = 2'd1;
  localparam logic [1:0] CMD_TICK    = 2'd2;

  // result kinds
  typedef enum logic [2:0] {
    KIND_ACCEPT  = 3'd0,
    KIND_INVALID = 3'd1,
    KIND_RAISE   = 3'd2,
    KIND_CLEAR   = 3'd3,
    KIND_SUMMARY = 3'd4
  } kind_t;

  // configuration reset values
  localparam logic [15:0] REPEAT_RESET = 16'd60;
  localparam logic [31:0] AUTO_RESET   = 32'h0080_7E0;
  localparam logic [31:0] STOP_RESET   = 32'h0000_2023;
  localparam logic [31:0] COLD_RESET   = 32'h0000_0804;
  localparam logic [31:0] HOT_RESET    = 32'h0008_0040;

  // configuration registers as seen by the sequencer
  typedef struct packed {
    logic [15:0]           repeat_interval;
    logic [MAX_ALARMS-1:0] auto_clear;
    logic [MAX_ALARMS-1:0] service_stop;
    logic [MAX_ALARMS-1:0] cold_block;
    logic [MAX_ALARMS-1:0] hot_block;
  } cfg_t;

  // one result item
  typedef struct packed {
    kind_t                 kind;
    logic [4:0]            notice_index;
    logic [MAX_ALARMS-1:0] active_flags;
    logic                  close_hot;
    logic                  close_cold;
    logic                  out_of_service;
    logic                  enter_fatal;
    logic                  return_standby;
    logic                  last;
  } result_t;

endpackage

[rtl/anm_ram.sv]
// generic single-port-write, single-port-read ram with registered read data
module anm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                       clk,
  input  logic                                       wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                           wr_data,
  input  logic                                       rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                           rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/anm_cfg.sv]
// apb configuration registers of the alarm notify manager
module anm_cfg #(
  parameter int NUM_ALARMS = anm_pkg::NUM_ALARMS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output anm_pkg::cfg_t     cfg
);

  // register indexes
  localparam logic [2:0] REG_REPEAT = 3'd0;
  localparam logic [2:0] REG_AUTO   = 3'd1;
  localparam logic [2:0] REG_STOP   = 3'd2;
  localparam logic [2:0] REG_COLD   = 3'd3;
  localparam logic [2:0] REG_HOT    = 3'd4;

  localparam logic [32:0] ONES     = (33'd1 << NUM_ALARMS) - 33'd1;
  localparam logic [31:0] IDX_MASK = ONES[31:0];

  logic [15:0] repeat_r;
  logic [31:0] auto_r;
  logic [31:0] stop_r;
  logic [31:0] cold_r;
  logic [31:0] hot_r;
  logic        wr;

  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      repeat_r <= anm_pkg::REPEAT_RESET;
      auto_r   <= anm_pkg::AUTO_RESET & IDX_MASK;
      stop_r   <= anm_pkg::STOP_RESET & IDX_MASK;
      cold_r   <= anm_pkg::COLD_RESET & IDX_MASK;
      hot_r    <= anm_pkg::HOT_RESET & IDX_MASK;
    end else if (wr) begin
      unique case (paddr[4:2])
        REG_REPEAT: repeat_r <= pwdata[15:0];
        REG_AUTO:   auto_r   <= pwdata & IDX_MASK;
        REG_STOP:   stop_r   <= pwdata & IDX_MASK;
        REG_COLD:   cold_r   <= pwdata & IDX_MASK;
        REG_HOT:    hot_r    <= pwdata & IDX_MASK;
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (paddr[4:2])
      REG_REPEAT: prdata = 32'(repeat_r);
      REG_AUTO:   prdata = auto_r;
      REG_STOP:   prdata = stop_r;
      REG_COLD:   prdata = cold_r;
      REG_HOT:    prdata = hot_r;
      default:    prdata = '0;
    endcase
  end

  assign cfg.repeat_interval = repeat_r;
  assign cfg.auto_clear      = auto_r;
  assign cfg.service_stop    = stop_r;
  assign cfg.cold_block      = cold_r;
  assign cfg.hot_block       = hot_r;

endmodule

[rtl/anm_engine.sv]
// command and tick sequencer around the alarm table ram
module anm_engine #(
  parameter int NUM_ALARMS = anm_pkg::NUM_ALARMS_DEF,
  parameter int COUNT_BITS = anm_pkg::COUNT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_cmd,
  input  logic [4:0]          in_alarm_index,
  input  anm_pkg::cfg_t       cfg,
  input  logic                out_free,
  output logic                emit,
  output anm_pkg::result_t    res
);

  localparam int AW = (NUM_ALARMS > 1) ? $clog2(NUM_ALARMS) : 1;
  localparam int AB = anm_pkg::AGE_BITS;
  localparam int EW = 2 + COUNT_BITS + AB;
  localparam logic [AW-1:0]         LAST_ADDR = AW'(NUM_ALARMS - 1);
  localparam logic [5:0]            NUM_IDX   = 6'(NUM_ALARMS);
  localparam logic [COUNT_BITS-1:0] CNT_MAX   = '1;
  localparam logic [AB-1:0]         AGE_MAX   = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMD,
    ST_WALK,
    ST_SUM
  } state_t;

  state_t                  st_r, st_nxt;
  logic [1:0]              cmd_r;
  logic [4:0]              idx_r;
  logic [AW-1:0]           cnt_r, cnt_nxt;
  logic [NUM_ALARMS-1:0]   active_r, active_nxt;
  logic                    stopped_r, stopped_nxt;
  logic [NUM_ALARMS-1:0]   vld_r;
  logic                    rd_vld_r;

  logic                    accept;
  logic                    idx_ok;
  logic                    in_idx_ok;
  logic                    rd_en, wr_en;
  logic [AW-1:0]           rd_addr, wr_addr;
  logic [EW-1:0]           rd_data, wr_data;
  logic [EW-1:0]           ent;
  logic                    e_raised, e_res;
  logic [COUNT_BITS-1:0]   e_cnt;
  logic [AB-1:0]           e_age, age_inc;
  logic                    overdue;
  logic [NUM_ALARMS-1:0]   hot_m, cold_m, stop_m, auto_m;

  assign in_stall  = (st_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign idx_ok    = ({1'b0, idx_r} < NUM_IDX);
  assign in_idx_ok = ({1'b0, in_alarm_index} < NUM_IDX);

  assign hot_m  = cfg.hot_block[NUM_ALARMS-1:0];
  assign cold_m = cfg.cold_block[NUM_ALARMS-1:0];
  assign stop_m = cfg.service_stop[NUM_ALARMS-1:0];
  assign auto_m = cfg.auto_clear[NUM_ALARMS-1:0];

  // alarm table: {raised, resolving, repeat count, notice age}
  anm_ram #(
    .WIDTH (EW),
    .DEPTH (NUM_ALARMS)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // entries never written read as zero
  assign ent      = rd_vld_r ? rd_data : '0;
  assign e_raised = ent[EW-1];
  assign e_res    = ent[EW-2];
  assign e_cnt    = ent[AB +: COUNT_BITS];
  assign e_age    = ent[AB-1:0];
  assign age_inc  = (e_age != AGE_MAX) ? (e_age + 1'b1) : e_age;
  assign overdue  = (age_inc > AB'(cfg.repeat_interval));

  // sequencing and read-modify-write of one entry
  always_comb begin
    st_nxt      = st_r;
    cnt_nxt     = cnt_r;
    active_nxt  = active_r;
    stopped_nxt = stopped_r;
    rd_en       = 1'b0;
    rd_addr     = '0;
    wr_en       = 1'b0;
    wr_addr     = cnt_r;
    wr_data     = ent;
    emit        = 1'b0;
    res         = '0;
    res.kind    = anm_pkg::KIND_ACCEPT;
    unique case (st_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_cmd == anm_pkg::CMD_TICK) begin
            rd_en   = 1'b1;
            cnt_nxt = '0;
            st_nxt  = ST_WALK;
          end else begin
            rd_en   = in_idx_ok;
            rd_addr = in_alarm_index[AW-1:0];
            st_nxt  = ST_CMD;
          end
        end
      end
      ST_CMD: begin
        if (out_free) begin
          emit             = 1'b1;
          res.notice_index = idx_r;
          res.last         = 1'b1;
          wr_addr          = idx_r[AW-1:0];
          st_nxt           = ST_IDLE;
          if (idx_ok && cmd_r == anm_pkg::CMD_RAISE) begin
            wr_en = 1'b1;
            if (e_cnt != CNT_MAX) begin
              wr_data[AB +: COUNT_BITS] = e_cnt + 1'b1;
            end
            if (!e_raised) begin
              wr_data[EW-1]   = 1'b1;
              wr_data[AB-1:0] = AB'(cfg.repeat_interval);
            end
          end else if (idx_ok && cmd_r == anm_pkg::CMD_RESOLVE) begin
            wr_en         = e_raised;
            wr_data[EW-2] = 1'b1;
          end else begin
            res.kind = anm_pkg::KIND_INVALID;
          end
        end
      end
      ST_WALK: begin
        if (out_free) begin
          wr_en = e_raised;
          if (e_raised) begin
            if (e_res) begin
              active_nxt[cnt_r] = 1'b0;
              wr_data           = '0;
              emit              = 1'b1;
              res.kind          = anm_pkg::KIND_CLEAR;
            end else begin
              active_nxt[cnt_r] = 1'b1;
              wr_data[AB-1:0]   = age_inc;
              if (overdue) begin
                if (auto_m[cnt_r] && e_cnt == '0) begin
                  wr_data[EW-2] = 1'b1;
                end else begin
                  wr_data[AB +: COUNT_BITS] = auto_m[cnt_r] ? '0 : e_cnt;
                  wr_data[AB-1:0]           = '0;
                  emit                      = 1'b1;
                  res.kind                  = anm_pkg::KIND_RAISE;
                end
              end
            end
          end
          res.notice_index = 5'(cnt_r);
          if (cnt_r == LAST_ADDR) begin
            st_nxt = ST_SUM;
          end else begin
            rd_en   = 1'b1;
            rd_addr = cnt_r + 1'b1;
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      ST_SUM: begin
        if (out_free) begin
          emit           = 1'b1;
          res.kind       = anm_pkg::KIND_SUMMARY;
          res.close_hot  = |(active_r & hot_m);
          res.close_cold = |(active_r & cold_m);
          res.last       = 1'b1;
          stopped_nxt    = |(active_r & stop_m);
          res.enter_fatal    = stopped_nxt && !stopped_r;
          res.return_standby = !stopped_nxt && stopped_r;
          st_nxt         = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
    res.active_flags   = anm_pkg::MAX_ALARMS'(active_nxt);
    res.out_of_service = stopped_nxt;
  end

  // state, command capture and entry valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_IDLE;
      cnt_r     <= '0;
      active_r  <= '0;
      stopped_r <= 1'b0;
      vld_r     <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      cnt_r     <= cnt_nxt;
      active_r  <= active_nxt;
      stopped_r <= stopped_nxt;
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_cmd;
      idx_r <= in_alarm_index;
    end
  end

  // walk index stays inside the table
  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_WALK) |-> (cnt_r <= LAST_ADDR))
    else $error("walk index beyond table");

  // a tick starts its walk at entry zero
  assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_cmd == anm_pkg::CMD_TICK) |=> (st_r == ST_WALK && cnt_r == '0))
    else $error("tick walk did not start at entry zero");

  // the out-of-service flag only moves in the summary step
  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != ST_SUM) |=> $stable(stopped_r))
    else $error("out-of-service changed outside the summary");

endmodule

[rtl/alarm_notify_manager_unit.sv]
// Alarm notify manager top level: configuration registers, sequencer and result register.
// Keeps a table of NUM_ALARMS alarm sources in one ram entry per source. A raise or
// resolve command reads its table entry, then modifies and writes it back as its result
// is loaded into the result register; the next item is taken once the sequencer is idle.
// A tick walks the table, then a summary step loads its summary; the walk handles one
// table entry per cycle while the result register is free, through the single ram read
// port, and reads one entry in the same cycle as it writes back the neighboring one.
// A stalled result register holds the sequencer where it is. The user must write the
// configuration through the apb port only while idle; the block does not enforce it.
module alarm_notify_manager_unit #(
  parameter int NUM_ALARMS = anm_pkg::NUM_ALARMS_DEF,
  parameter int COUNT_BITS = anm_pkg::COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [4:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_cmd,
  input  logic [4:0]            in_alarm_index,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [2:0]            out_kind,
  output logic [4:0]            out_notice_index,
  output logic [NUM_ALARMS-1:0] out_active_flags,
  output logic                  out_close_hot,
  output logic                  out_close_cold,
  output logic                  out_out_of_service,
  output logic                  out_enter_fatal,
  output logic                  out_return_standby,
  output logic                  out_last
);

  anm_pkg::cfg_t    cfg;
  anm_pkg::result_t res;
  anm_pkg::result_t res_r;
  logic             emit;
  logic             out_free;
  logic             out_valid_r;

  anm_cfg #(
    .NUM_ALARMS (NUM_ALARMS)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  anm_engine #(
    .NUM_ALARMS (NUM_ALARMS),
    .COUNT_BITS (COUNT_BITS)
  ) u_engine (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_alarm_index (in_alarm_index),
    .cfg            (cfg),
    .out_free       (out_free),
    .emit           (emit),
    .res            (res)
  );

  // result register: free when empty or being taken
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = res_r.kind;
  assign out_notice_index   = res_r.notice_index;
  assign out_active_flags   = res_r.active_flags[NUM_ALARMS-1:0];
  assign out_close_hot      = res_r.close_hot;
  assign out_close_cold     = res_r.close_cold;
  assign out_out_of_service = res_r.out_of_service;
  assign out_enter_fatal    = res_r.enter_fatal;
  assign out_return_standby = res_r.return_standby;
  assign out_last           = res_r.last;

  // a new item never overwrites one that is still waiting
  assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> out_free)
    else $error("result loaded over a stalled item");

  // entry into and exit from out-of-service never coincide
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_enter_fatal && out_return_standby))
    else $error("enter and exit of out-of-service together");

  // command answers are single items
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_kind == anm_pkg::KIND_ACCEPT || out_kind == anm_pkg::KIND_INVALID))
      |-> out_last)
    else $error("command answer without last");

endmodule
